// ----- src/pdv_pkg.sv -----
// ----------------------------------------------------------------------------
// pdv_pkg
// Shared types and constants for the validating percent decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdv_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int OUT_COUNT_W     = 16;

	localparam logic [7:0] CH_QMARK  = 8'h3f;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CASE_BIT  = 8'h20;
	localparam logic [7:0] RANGE_LO  = 8'h25;
	localparam logic [7:0] RANGE_HI  = 8'h7f;
	localparam logic [7:0] NUL_BYTE  = 8'h00;

	localparam int MODE_URI   = 0;
	localparam int MODE_REDIR = 1;

	typedef enum logic [1:0] {
		PH_USUAL  = 2'd0,
		PH_FIRST  = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0]             out_byte;
		logic                   byte_valid;
		logic                   end_of_string;
		logic [OUT_COUNT_W-1:0] anomaly_count;
	} out_word_t;

	// one decoded item: up to three bytes in emit order
	typedef struct packed {
		logic [2:0][7:0]        bytes;
		logic [1:0]             n;
		logic                   last;
		logic [OUT_COUNT_W-1:0] cnt;
	} job_t;

endpackage

// ----- src/pdv_front.sv -----
// ----------------------------------------------------------------------------
// pdv_front
// Accepts raw bytes, tracks escape state and builds the bytes of each word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdv_front #(
	parameter int COUNT_WIDTH = pdv_pkg::COUNT_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata,
	input  logic             accept,
	input  pdv_pkg::in_word_t in_word,
	output pdv_pkg::job_t    job,
	output logic             job_vld
);

	localparam int WW = (COUNT_WIDTH > pdv_pkg::OUT_COUNT_W) ? COUNT_WIDTH :
		pdv_pkg::OUT_COUNT_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [1:0]             mode_q;
	pdv_pkg::phase_t        phase_q;
	logic [3:0]             nib_q;
	logic [7:0]             raw_q;
	logic                   stop_q;
	logic [COUNT_WIDTH-1:0] anom_q;

	pdv_pkg::phase_t        nxt_phase;
	logic [3:0]             nxt_nib;
	logic [7:0]             nxt_raw;
	logic                   nxt_stop;
	logic [2:0][7:0]        raw;
	logic [1:0]             n;
	logic                   bad;

	logic [7:0]             b;
	logic [7:0]             lc;
	logic                   is_dig;
	logic                   is_let;
	logic [3:0]             nib;
	logic [7:0]             v;
	logic                   in_rng;
	logic [7:0]             fch;
	logic                   uri;
	logic                   redir;
	logic [2:0]             inc;
	logic [COUNT_WIDTH:0]   sum;
	logic [COUNT_WIDTH-1:0] nxt_anom;
	logic [WW-1:0]          anom_ext;

	assign b      = in_word.in_byte;
	assign lc     = b | pdv_pkg::CASE_BIT;
	assign is_dig = (b >= pdv_pkg::CH_ZERO) && (b <= pdv_pkg::CH_NINE);
	assign is_let = (lc >= pdv_pkg::CH_LOW_A) && (lc <= pdv_pkg::CH_LOW_F);
	assign nib    = is_dig ? b[3:0] : (lc[3:0] + 4'd9);
	assign v      = {nib_q, nib};
	assign in_rng = (v > pdv_pkg::RANGE_LO) && (v < pdv_pkg::RANGE_HI);
	assign fch    = (nib_q < 4'd10) ? (pdv_pkg::CH_ZERO + {4'h0, nib_q}) :
		(pdv_pkg::CH_LOW_A + {4'h0, nib_q - 4'd10});
	assign uri    = mode_q[pdv_pkg::MODE_URI];
	assign redir  = mode_q[pdv_pkg::MODE_REDIR];

	always_comb begin
		raw       = '0;
		n         = 2'd0;
		bad       = 1'b0;
		nxt_phase = phase_q;
		nxt_nib   = nib_q;
		nxt_raw   = raw_q;
		nxt_stop  = stop_q;
		if (!stop_q) begin
			case (phase_q)
				pdv_pkg::PH_FIRST: begin
					if (is_dig || is_let) begin
						nxt_nib   = nib;
						nxt_raw   = b;
						nxt_phase = pdv_pkg::PH_SECOND;
					end else begin
						bad       = 1'b1;
						raw[0]    = pdv_pkg::CH_PCT;
						raw[1]    = b;
						n         = 2'd2;
						nxt_phase = pdv_pkg::PH_USUAL;
					end
				end
				pdv_pkg::PH_SECOND: begin
					nxt_phase = pdv_pkg::PH_USUAL;
					if (is_dig) begin
						if (redir && !in_rng) begin
							raw = {b, raw_q, pdv_pkg::CH_PCT};
							n   = 2'd3;
						end else begin
							raw[0] = v;
							n      = 2'd1;
						end
					end else if (is_let) begin
						if (uri) begin
							raw[0]   = v;
							n        = 2'd1;
							nxt_stop = (v == pdv_pkg::CH_QMARK);
						end else if (redir) begin
							if (v == pdv_pkg::CH_QMARK) begin
								raw[0]   = v;
								n        = 2'd1;
								nxt_stop = 1'b1;
							end else if (in_rng) begin
								raw[0] = v;
								n      = 2'd1;
							end else begin
								raw = {b, raw_q, pdv_pkg::CH_PCT};
								n   = 2'd3;
							end
						end else begin
							raw[0] = v;
							n      = 2'd1;
						end
					end else begin
						raw = {b, fch, pdv_pkg::CH_PCT};
						n   = 2'd3;
						bad = 1'b1;
					end
				end
				default: begin
					nxt_phase = pdv_pkg::PH_USUAL;
					if ((b == pdv_pkg::CH_QMARK) && (uri || redir)) begin
						raw[0]   = b;
						n        = 2'd1;
						nxt_stop = 1'b1;
					end else if (b == pdv_pkg::CH_PCT) begin
						nxt_phase = pdv_pkg::PH_FIRST;
					end else begin
						raw[0] = b;
						n      = 2'd1;
					end
				end
			endcase
		end
	end

	// null bytes become '0' and count as anomalies
	always_comb begin
		inc = {2'b00, bad};
		for (int i = 0; i < 3; i++) begin
			if ((2'(i) < n) && (raw[i] == pdv_pkg::NUL_BYTE)) begin
				inc = inc + 3'd1;
			end
		end
	end

	assign sum      = {1'b0, anom_q} + (COUNT_WIDTH + 1)'(inc);
	assign nxt_anom = sum[COUNT_WIDTH] ? CNT_MAX : sum[COUNT_WIDTH-1:0];
	assign anom_ext = WW'(nxt_anom);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			job.bytes[i] = (raw[i] == pdv_pkg::NUL_BYTE) ? pdv_pkg::CH_ZERO : raw[i];
		end
		job.n    = n;
		job.last = in_word.in_last;
		job.cnt  = (anom_ext > WW'({pdv_pkg::OUT_COUNT_W{1'b1}})) ?
			{pdv_pkg::OUT_COUNT_W{1'b1}} : anom_ext[pdv_pkg::OUT_COUNT_W-1:0];
	end

	assign job_vld = accept && ((n != 2'd0) || in_word.in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= '0;
			phase_q <= pdv_pkg::PH_USUAL;
			nib_q   <= '0;
			raw_q   <= '0;
			stop_q  <= 1'b0;
			anom_q  <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (accept) begin
				if (in_word.in_last) begin
					phase_q <= pdv_pkg::PH_USUAL;
					nib_q   <= '0;
					raw_q   <= '0;
					stop_q  <= 1'b0;
					anom_q  <= '0;
				end else begin
					phase_q <= nxt_phase;
					nib_q   <= nxt_nib;
					raw_q   <= nxt_raw;
					stop_q  <= nxt_stop;
					anom_q  <= nxt_anom;
				end
			end
		end
	end

endmodule

// ----- src/pdv_queue.sv -----
// ----------------------------------------------------------------------------
// pdv_queue
// Short first-in first-out queue of decoded items between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdv_queue #(
	parameter int QUEUE_DEPTH = pdv_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  pdv_pkg::job_t wr_job,
	input  logic          rd,
	output pdv_pkg::job_t rd_job,
	output logic          full,
	output logic          nonempty
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

	pdv_pkg::job_t   mem_q [QUEUE_DEPTH];
	logic [AW-1:0]   wp_q;
	logic [AW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full     = (cnt_q == CW'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign do_wr    = wr && !full;
	assign do_rd    = rd && nonempty;
	assign rd_job   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == LAST_IDX) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/pdv_back.sv -----
// ----------------------------------------------------------------------------
// pdv_back
// Walks the bytes of each queued item and presents them one word at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdv_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pdv_pkg::job_t      head,
	input  logic               head_vld,
	output logic               head_rd,
	input  logic               pop,
	output logic               empty,
	output pdv_pkg::out_word_t out_word
);

	pdv_pkg::job_t cur_q;
	logic          cur_vld_q;
	logic [1:0]    idx_q;
	logic          at_end;
	logic          take;

	assign at_end  = (cur_q.n == 2'd0) || (idx_q == (cur_q.n - 2'd1));
	assign take    = !cur_vld_q || (pop && at_end);
	assign head_rd = take && head_vld;
	assign empty   = !cur_vld_q;

	always_comb begin
		out_word.byte_valid    = (cur_q.n != 2'd0);
		out_word.out_byte      = out_word.byte_valid ? cur_q.bytes[idx_q] : '0;
		out_word.end_of_string = cur_q.last && at_end;
		out_word.anomaly_count = out_word.end_of_string ? cur_q.cnt : '0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
		end else if (take) begin
			cur_vld_q <= head_vld;
			idx_q     <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// ----- src/percent_decode_validating.sv -----
// ----------------------------------------------------------------------------
// percent_decode_validating
// Path: an accepted byte's item is written into the item queue and loaded into
// the back end's current-item register, whose contents drive the outputs.
// Throughput: one byte per cycle; an item yielding k bytes holds the back end
// for k pops, and the front stalls once the item queue fills.
// Reset: asynchronous, clears the mode register, escape state and queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module percent_decode_validating #(
	parameter int COUNT_WIDTH = pdv_pkg::COUNT_WIDTH_DEF,
	parameter int QUEUE_DEPTH = pdv_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	input  logic               push,
	output logic               full,
	input  pdv_pkg::in_word_t  in_word,
	output logic               empty,
	input  logic               pop,
	output pdv_pkg::out_word_t out_word
);

	pdv_pkg::job_t f_job;
	logic          f_vld;
	pdv_pkg::job_t q_head;
	logic          q_nonempty;
	logic          q_rd;
	logic          accept;

	assign accept = push && !full;

	pdv_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.accept   (accept),
		.in_word  (in_word),
		.job      (f_job),
		.job_vld  (f_vld)
	);

	pdv_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (f_vld),
		.wr_job  (f_job),
		.rd      (q_rd),
		.rd_job  (q_head),
		.full    (full),
		.nonempty(q_nonempty)
	);

	pdv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.head_vld(q_nonempty),
		.head_rd (q_rd),
		.pop     (pop),
		.empty   (empty),
		.out_word(out_word)
	);

	a_count_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_word.end_of_string) |-> (out_word.anomaly_count == '0))
		else $error("anomaly count shown before end of string");

	a_empty_word_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !out_word.byte_valid) |-> out_word.end_of_string)
		else $error("word without byte does not end a string");

	a_no_null_out: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_word.byte_valid) |-> (out_word.out_byte != 8'h00))
		else $error("null byte reached the output");

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the validating percent decoder. A queue of string
// bytes feeds a clocked driver with random gaps, and a clocked monitor pops
// words with random stalls. Every accepted byte is decoded by an in-bench
// model of the escape state machine, and each popped word is compared field
// by field with the oldest predicted word. The run steps through every mode
// setting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int CNT_W          = 8;
	localparam int CNT_MAX        = (1 << CNT_W) - 1;
	localparam int OUT_W          = pdv_pkg::OUT_COUNT_W;
	localparam int RUN_LIMIT_NS   = 5_000_000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RAND_PER_PHASE = 6;

	localparam logic [1:0] MD_PLAIN = 2'b00;
	localparam logic [1:0] MD_URI   = 2'b01;
	localparam logic [1:0] MD_REDIR = 2'b10;
	localparam logic [1:0] MD_BOTH  = 2'b11;

	typedef enum int {HEX_NONE, HEX_DIGIT, HEX_LETTER} hex_kind_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [1:0]         cfg_wdata = '0;
	logic               push      = 1'b0;
	logic               full;
	pdv_pkg::in_word_t  in_word   = '0;
	logic               empty;
	logic               pop       = 1'b0;
	pdv_pkg::out_word_t out_word;

	percent_decode_validating #(.COUNT_WIDTH(CNT_W)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.push     (push),
		.full     (full),
		.in_word  (in_word),
		.empty    (empty),
		.pop      (pop),
		.out_word (out_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder model state
	logic [1:0]         dec_mode    = MD_PLAIN;
	pdv_pkg::phase_t    dec_phase   = pdv_pkg::PH_USUAL;
	logic [3:0]         dec_nib     = '0;
	logic [7:0]         dec_raw     = '0;
	logic               dec_stopped = 1'b0;
	int                 dec_anoms   = 0;
	pdv_pkg::out_word_t word_buf[3];
	int                 word_n;

	pdv_pkg::out_word_t want_words[$];
	pdv_pkg::in_word_t  pending_bytes[$];

	int   gap_left    = 0;
	int   stall_left  = 0;
	logic idle_on     = 1'b1;
	int   rand_left;
	int   bytes_in    = 0;
	int   words_out   = 0;
	int   errors      = 0;

	logic [1:0] mode_seq[8] = '{MD_PLAIN, MD_URI, MD_REDIR, MD_BOTH,
		MD_REDIR, MD_PLAIN, MD_BOTH, MD_URI};

	function automatic int pick_gap();
		int r;
		if ($urandom_range(0, 59) == 0)
			idle_on = !idle_on;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic hex_kind_t hex_kind(input logic [7:0] b, output logic [3:0] nib);
		logic [7:0] lc;
		logic [7:0] d;
		lc  = b | pdv_pkg::CASE_BIT;
		nib = '0;
		if (b >= pdv_pkg::CH_ZERO && b <= pdv_pkg::CH_NINE) begin
			d   = b - pdv_pkg::CH_ZERO;
			nib = d[3:0];
			return HEX_DIGIT;
		end
		if (lc >= pdv_pkg::CH_LOW_A && lc <= pdv_pkg::CH_LOW_F) begin
			d   = lc - pdv_pkg::CH_LOW_A + 8'd10;
			nib = d[3:0];
			return HEX_LETTER;
		end
		return HEX_NONE;
	endfunction

	task automatic count_anomaly();
		if (dec_anoms < CNT_MAX)
			dec_anoms++;
	endtask

	task automatic put_byte(input logic [7:0] b);
		logic [7:0] v;
		v = b;
		if (v == pdv_pkg::NUL_BYTE) begin
			v = pdv_pkg::CH_ZERO;
			count_anomaly();
		end
		if (word_n < 3) begin
			word_buf[word_n]            = '0;
			word_buf[word_n].out_byte   = v;
			word_buf[word_n].byte_valid = 1'b1;
			word_n++;
		end
	endtask

	// escape given back as its three raw characters
	task automatic restore_escape(input logic [7:0] b);
		put_byte(pdv_pkg::CH_PCT);
		put_byte(dec_raw);
		put_byte(b);
	endtask

	task automatic decode_byte(input pdv_pkg::in_word_t w);
		logic [7:0] b;
		logic [7:0] v;
		logic [3:0] nib;
		logic       in_range;
		hex_kind_t  kind;
		b      = w.in_byte;
		word_n = 0;
		if (!dec_stopped) begin
			case (dec_phase)
				pdv_pkg::PH_FIRST: begin
					kind = hex_kind(b, nib);
					if (kind != HEX_NONE) begin
						dec_nib   = nib;
						dec_raw   = b;
						dec_phase = pdv_pkg::PH_SECOND;
					end else begin
						count_anomaly();
						put_byte(pdv_pkg::CH_PCT);
						put_byte(b);
						dec_phase = pdv_pkg::PH_USUAL;
					end
				end
				pdv_pkg::PH_SECOND: begin
					dec_phase = pdv_pkg::PH_USUAL;
					kind      = hex_kind(b, nib);
					v         = {dec_nib, nib};
					in_range  = v > pdv_pkg::RANGE_LO && v < pdv_pkg::RANGE_HI;
					if (kind == HEX_DIGIT) begin
						if (dec_mode[pdv_pkg::MODE_REDIR] && !in_range)
							restore_escape(b);
						else
							put_byte(v);
					end else if (kind == HEX_LETTER) begin
						if (dec_mode[pdv_pkg::MODE_URI]) begin
							put_byte(v);
							if (v == pdv_pkg::CH_QMARK)
								dec_stopped = 1'b1;
						end else if (dec_mode[pdv_pkg::MODE_REDIR]) begin
							if (v == pdv_pkg::CH_QMARK) begin
								put_byte(v);
								dec_stopped = 1'b1;
							end else if (in_range) begin
								put_byte(v);
							end else begin
								restore_escape(b);
							end
						end else begin
							put_byte(v);
						end
					end else begin
						// first digit comes back in lower case
						put_byte(pdv_pkg::CH_PCT);
						if (dec_nib < 4'd10)
							put_byte(pdv_pkg::CH_ZERO + dec_nib);
						else
							put_byte(pdv_pkg::CH_LOW_A + dec_nib - 8'd10);
						put_byte(b);
						count_anomaly();
					end
				end
				default: begin
					dec_phase = pdv_pkg::PH_USUAL;
					if (b == pdv_pkg::CH_QMARK && dec_mode != MD_PLAIN) begin
						put_byte(b);
						dec_stopped = 1'b1;
					end else if (b == pdv_pkg::CH_PCT) begin
						dec_phase = pdv_pkg::PH_FIRST;
					end else begin
						put_byte(b);
					end
				end
			endcase
		end
		if (w.in_last) begin
			if (word_n == 0) begin
				word_buf[0] = '0;
				word_n      = 1;
			end
			word_buf[word_n-1].end_of_string = 1'b1;
			word_buf[word_n-1].anomaly_count = OUT_W'(dec_anoms);
			dec_phase   = pdv_pkg::PH_USUAL;
			dec_nib     = '0;
			dec_raw     = '0;
			dec_stopped = 1'b0;
			dec_anoms   = 0;
		end
		for (int i = 0; i < word_n; i++)
			want_words.push_back(word_buf[i]);
	endtask

	task automatic check_word(input pdv_pkg::out_word_t got);
		pdv_pkg::out_word_t exp;
		words_out++;
		if (want_words.size() == 0) begin
			$error("unexpected word %h", got);
			errors++;
		end else begin
			exp = want_words.pop_front();
			if (got.out_byte !== exp.out_byte) begin
				$error("out_byte: expected %0h, got %0h", exp.out_byte, got.out_byte);
				errors++;
			end
			if (got.byte_valid !== exp.byte_valid) begin
				$error("byte_valid: expected %0b, got %0b", exp.byte_valid, got.byte_valid);
				errors++;
			end
			if (got.end_of_string !== exp.end_of_string) begin
				$error("end_of_string: expected %0b, got %0b", exp.end_of_string,
					got.end_of_string);
				errors++;
			end
			if (got.anomaly_count !== exp.anomaly_count) begin
				$error("anomaly_count: expected %0d, got %0d", exp.anomaly_count,
					got.anomaly_count);
				errors++;
			end
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || !full) begin
			if (push) begin
				decode_byte(in_word);
				bytes_in++;
			end
			if (gap_left != 0 || pending_bytes.size() == 0) begin
				push <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end else begin
				in_word  <= pending_bytes.pop_front();
				push     <= 1'b1;
				gap_left = pick_gap();
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				check_word(out_word);
			if (stall_left != 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				if (pop && !empty)
					stall_left = pick_gap();
				pop <= (stall_left == 0);
			end
		end
	end

	task automatic add_byte(input logic [7:0] b, input logic last);
		pdv_pkg::in_word_t w;
		w.in_byte = b;
		w.in_last = last;
		pending_bytes.push_back(w);
	endtask

	task automatic add_text(input string s, input logic last_at_end);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], last_at_end && i == s.len() - 1);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10)
			return pdv_pkg::CH_ZERO + n;
		c = pdv_pkg::CH_LOW_A + n - 8'd10;
		if ($urandom_range(0, 1) == 1)
			c = c & ~pdv_pkg::CASE_BIT;
		return c;
	endfunction

	task automatic add_random_string();
		logic [7:0] s[$];
		int tokens;
		int r;
		tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
		repeat (tokens) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				s.push_back(pdv_pkg::CH_PCT);
				s.push_back(hex_char(4'($urandom_range(0, 15))));
				s.push_back(hex_char(4'($urandom_range(0, 15))));
			end else if (r < 50) begin
				s.push_back(pdv_pkg::CH_PCT);
				s.push_back(8'($urandom_range(0, 255)));
			end else if (r < 58) begin
				s.push_back(pdv_pkg::CH_PCT);
				s.push_back(hex_char(4'($urandom_range(0, 15))));
				s.push_back(8'($urandom_range(0, 255)));
			end else if (r < 66) begin
				s.push_back(pdv_pkg::CH_QMARK);
			end else if (r < 71) begin
				s.push_back(pdv_pkg::NUL_BYTE);
			end else if (r < 74) begin
				s.push_back(pdv_pkg::CH_PCT);
			end else begin
				s.push_back(8'($urandom_range(0, 255)));
			end
		end
		foreach (s[i])
			add_byte(s[i], i == s.size() - 1);
		rand_left -= s.size();
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() != 0 || push || want_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] m);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		dec_mode  = m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (mode_seq[p]) begin
			wait_idle();
			write_mode(mode_seq[p]);
			if (p < 4) begin
				case (mode_seq[p])
					MD_PLAIN: begin
						add_byte(pdv_pkg::NUL_BYTE, 1'b0);
						add_text("%41%z%4Z%00?%4", 1'b1);
					end
					MD_URI:   add_text("a%3Fb", 1'b1);
					MD_REDIR: add_text("%20%7f", 1'b1);
					MD_BOTH:  add_text("%10%1c", 1'b1);
					default: ;
				endcase
			end
			rand_left = RAND_PER_PHASE;
			while (rand_left > 0)
				add_random_string();
		end
		wait_idle();
		if (want_words.size() != 0) begin
			$error("%0d words never arrived", want_words.size());
			errors++;
		end
		$display("%0d bytes decoded into %0d words across %0d mode settings",
			bytes_in, words_out, $size(mode_seq));
		$display("escapes, bad escapes, null bytes, stops and pending ends exercised");
		if (errors == 0)
			$display("percent_decode_validating: match");
		else
			$display("percent_decode_validating: mismatch");
		$finish;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("percent_decode_validating: mismatch");
		$finish;
	end

endmodule
